[design/sphere_frustum_distance_cull_core_macros.svh]
// Assertion macros for the sphere frustum and distance cull core.
`ifndef SPHERE_FRUSTUM_DISTANCE_CULL_CORE_MACROS_SVH
`define SPHERE_FRUSTUM_DISTANCE_CULL_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define SFDC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfdc assertion failed");
// Next-cycle implication, sampled on clk, off during reset.
`define SFDC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfdc assertion failed");
`else
`define SFDC_ASSERT_IMPL(lbl, ante, cons)
`define SFDC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[design/sfdc_pkg.sv]
// Shared constants and widths for the sphere frustum and distance cull core.
`default_nettype none
package sfdc_pkg;

    localparam int COORD_BITS  = 16;
    localparam int INDEX_BITS  = 16;
    localparam int OUT_INDEX_BITS = 16;
    localparam int RADIUS_BITS = COORD_BITS - 1;
    localparam int LANE_BITS   = 16;
    localparam int NUM_PLANES  = 6;
    localparam int NORMAL_FRAC = 14;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 64;
    localparam int PLANE_BITS    = 64;
    localparam int CAMERA_BITS   = 48;
    localparam int CONTROL_BITS  = 18;
    localparam int DRAW_BITS     = 16;

    localparam logic [CONTROL_BITS-1:0] CONTROL_RESET = 18'h20000;
    localparam int CTRL_DIST_EN_BIT    = 16;
    localparam int CTRL_FRUSTUM_EN_BIT = 17;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_LEFT   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_TOP    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_NEAR   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_FAR    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_CAMERA       = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_CONTROL      = 3'd7;

    // distance path widths
    localparam int WIDE_IN_BITS = (COORD_BITS > LANE_BITS) ? COORD_BITS : LANE_BITS;
    localparam int DIFF_BITS    = WIDE_IN_BITS + 1;
    localparam int SQ_BITS      = 2 * WIDE_IN_BITS;
    localparam int SUM_BITS     = SQ_BITS + 2;
    localparam int LIM_BITS     = ((DRAW_BITS > RADIUS_BITS) ? DRAW_BITS : RADIUS_BITS) + 1;
    localparam int LIM2_BITS    = 2 * LIM_BITS;
    localparam int CMP_BITS     = (SUM_BITS > LIM2_BITS) ? SUM_BITS : LIM2_BITS;

    // plane path widths
    localparam int PROD_BITS = LANE_BITS + COORD_BITS;
    localparam int BASE_BITS = ((LANE_BITS > COORD_BITS) ? LANE_BITS : COORD_BITS)
                               + NORMAL_FRAC + 1;
    localparam int DOT_BITS  = ((PROD_BITS > BASE_BITS) ? PROD_BITS : BASE_BITS) + 2;

endpackage
`default_nettype wire

[design/sfdc_plane_dot.sv]
// One frustum plane: two-stage signed distance plus radius, sign flags a cull.
`default_nettype none
module sfdc_plane_dot (
    input  logic                                 clk,
    input  logic [sfdc_pkg::PLANE_BITS-1:0]      plane,
    input  logic signed [sfdc_pkg::COORD_BITS-1:0] cx,
    input  logic signed [sfdc_pkg::COORD_BITS-1:0] cy,
    input  logic signed [sfdc_pkg::COORD_BITS-1:0] cz,
    input  logic [sfdc_pkg::RADIUS_BITS-1:0]     radius,
    output logic                                 outside
);
    import sfdc_pkg::*;

    logic signed [LANE_BITS-1:0] nx, ny, nz, w;
    logic signed [PROD_BITS-1:0] px_reg, py_reg, pz_reg, px_next, py_next, pz_next;
    logic signed [BASE_BITS-1:0] base_reg, base_next;
    logic signed [DOT_BITS-1:0]  sum_reg, sum_next;

    assign nx = signed'(plane[0*LANE_BITS +: LANE_BITS]);
    assign ny = signed'(plane[1*LANE_BITS +: LANE_BITS]);
    assign nz = signed'(plane[2*LANE_BITS +: LANE_BITS]);
    assign w  = signed'(plane[3*LANE_BITS +: LANE_BITS]);

    // stage B: three products, offset and radius folded into one term
    always_comb
    begin
        px_next   = PROD_BITS'(nx) * PROD_BITS'(cx);
        py_next   = PROD_BITS'(ny) * PROD_BITS'(cy);
        pz_next   = PROD_BITS'(nz) * PROD_BITS'(cz);
        base_next = (BASE_BITS'(w) <<< NORMAL_FRAC)
                  + (BASE_BITS'(signed'({1'b0, radius})) <<< NORMAL_FRAC);
    end

    // stage C: dist + r*2^14, negative means fully outside
    always_comb
    begin
        sum_next = DOT_BITS'(px_reg) + DOT_BITS'(py_reg) + DOT_BITS'(pz_reg)
                 + DOT_BITS'(base_reg);
    end

    always_ff @(posedge clk)
    begin
        px_reg   <= px_next;
        py_reg   <= py_next;
        pz_reg   <= pz_next;
        base_reg <= base_next;
        sum_reg  <= sum_next;
    end

    assign outside = sum_reg[DOT_BITS-1];

endmodule
`default_nettype wire

[design/sphere_frustum_distance_cull_core.sv]
// Top level: bounding-sphere distance and six-plane frustum cull pipeline.
//
// Usage:
//   Input channel: an item (object_index, center_x/y/z, sphere_radius) is taken
//   at a clock edge with start high and busy low. busy is always low: the
//   pipeline takes one item every cycle, with no gaps.
//   Result channel: done is high for exactly one cycle with visible_index and
//   is_visible; the receiver cannot stall, so nothing upstream ever waits.
//   Pipeline: an item goes through four register stages (capture and camera
//   difference, multiply, add, compare) before done. Throughput is one item
//   per cycle, set by the fully pipelined multiplier banks (three squares,
//   eighteen plane products).
//   Config: cfg_write/cfg_index/cfg_data write one register per cycle;
//   change config only while no item is in flight.
//   Reset: planes and camera clear to zero, cull_control to frustum on,
//   distance off; all pipeline valid bits clear, so no stray done.
`default_nettype none
`include "sphere_frustum_distance_cull_core_macros.svh"
module sphere_frustum_distance_cull_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [sfdc_pkg::INDEX_BITS-1:0]        object_index,
    input  logic signed [sfdc_pkg::COORD_BITS-1:0] center_x,
    input  logic signed [sfdc_pkg::COORD_BITS-1:0] center_y,
    input  logic signed [sfdc_pkg::COORD_BITS-1:0] center_z,
    input  logic [sfdc_pkg::RADIUS_BITS-1:0]       sphere_radius,
    output logic                                   done,
    output logic [sfdc_pkg::OUT_INDEX_BITS-1:0]    visible_index,
    output logic                                   is_visible,
    input  logic                                   cfg_write,
    input  logic [sfdc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [sfdc_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import sfdc_pkg::*;

    // ---------------- configuration registers ----------------
    logic [PLANE_BITS-1:0]   plane_reg [NUM_PLANES];
    logic [PLANE_BITS-1:0]   plane_next [NUM_PLANES];
    logic [CAMERA_BITS-1:0]  camera_reg, camera_next;
    logic [CONTROL_BITS-1:0] control_reg, control_next;

    always_comb
    begin
        plane_next   = plane_reg;
        camera_next  = camera_reg;
        control_next = control_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PLANE_LEFT:   plane_next[0] = cfg_data[PLANE_BITS-1:0];
                REG_PLANE_RIGHT:  plane_next[1] = cfg_data[PLANE_BITS-1:0];
                REG_PLANE_BOTTOM: plane_next[2] = cfg_data[PLANE_BITS-1:0];
                REG_PLANE_TOP:    plane_next[3] = cfg_data[PLANE_BITS-1:0];
                REG_PLANE_NEAR:   plane_next[4] = cfg_data[PLANE_BITS-1:0];
                REG_PLANE_FAR:    plane_next[5] = cfg_data[PLANE_BITS-1:0];
                REG_CAMERA:       camera_next   = cfg_data[CAMERA_BITS-1:0];
                REG_CONTROL:      control_next  = cfg_data[CONTROL_BITS-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PLANES; i++)
            begin
                plane_reg[i] <= '0;
            end
            camera_reg  <= '0;
            control_reg <= CONTROL_RESET;
        end
        else
        begin
            plane_reg   <= plane_next;
            camera_reg  <= camera_next;
            control_reg <= control_next;
        end
    end

    // ---------------- valid chain ----------------
    logic accept;
    logic va_reg, vb_reg, vc_reg, done_reg;
    logic va_next, vb_next, vc_next, done_next;

    assign busy   = 1'b0;           // fully pipelined, never holds off start
    assign accept = start && !busy;

    always_comb
    begin
        va_next   = accept;
        vb_next   = va_reg;
        vc_next   = vb_reg;
        done_next = vc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            vc_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            va_reg   <= va_next;
            vb_reg   <= vb_next;
            vc_reg   <= vc_next;
            done_reg <= done_next;
        end
    end

    // ---------------- stage A: capture, center minus camera ----------------
    logic [INDEX_BITS-1:0]         idx_a_reg, idx_b_reg, idx_c_reg;
    logic [INDEX_BITS-1:0]         idx_a_next, idx_b_next, idx_c_next;
    logic signed [COORD_BITS-1:0]  cx_a_reg, cy_a_reg, cz_a_reg;
    logic signed [COORD_BITS-1:0]  cx_a_next, cy_a_next, cz_a_next;
    logic [RADIUS_BITS-1:0]        r_a_reg, r_a_next;
    logic signed [DIFF_BITS-1:0]   d_a_reg [3];
    logic signed [DIFF_BITS-1:0]   d_a_next [3];
    logic signed [COORD_BITS-1:0]  center_in [3];

    assign center_in[0] = center_x;
    assign center_in[1] = center_y;
    assign center_in[2] = center_z;

    always_comb
    begin
        idx_a_next = object_index;
        cx_a_next  = center_x;
        cy_a_next  = center_y;
        cz_a_next  = center_z;
        r_a_next   = sphere_radius;
        for (int k = 0; k < 3; k++)
        begin
            d_a_next[k] = DIFF_BITS'(center_in[k])
                        - DIFF_BITS'(signed'(camera_reg[k*LANE_BITS +: LANE_BITS]));
        end
    end

    // ---------------- stage B: squares and cull limit ----------------
    logic [SQ_BITS-1:0]                sq_b_reg [3];
    logic [SQ_BITS-1:0]                sq_b_next [3];
    logic signed [2*DIFF_BITS-1:0]     sq_full [3];
    logic [LIM_BITS-1:0]               lim_b_reg, lim_b_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sq_full[k]   = (2*DIFF_BITS)'(d_a_reg[k]) * (2*DIFF_BITS)'(d_a_reg[k]);
            sq_b_next[k] = sq_full[k][SQ_BITS-1:0];
        end
        lim_b_next = LIM_BITS'(control_reg[DRAW_BITS-1:0]) + LIM_BITS'(r_a_reg);
        idx_b_next = idx_a_reg;
    end

    // ---------------- stage C: sum of squares, limit squared ----------------
    logic [SUM_BITS-1:0]  sum_c_reg, sum_c_next;
    logic [LIM2_BITS-1:0] lim2_c_reg, lim2_c_next;

    always_comb
    begin
        sum_c_next  = SUM_BITS'(sq_b_reg[0]) + SUM_BITS'(sq_b_reg[1])
                    + SUM_BITS'(sq_b_reg[2]);
        lim2_c_next = LIM2_BITS'(lim_b_reg) * LIM2_BITS'(lim_b_reg);
        idx_c_next  = idx_b_reg;
    end

    // ---------------- plane tests (stages B and C inside) ----------------
    logic [NUM_PLANES-1:0] outside;

    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_plane
        sfdc_plane_dot u_dot (
            .clk     (clk),
            .plane   (plane_reg[p]),
            .cx      (cx_a_reg),
            .cy      (cy_a_reg),
            .cz      (cz_a_reg),
            .radius  (r_a_reg),
            .outside (outside[p])
        );
    end

    // ---------------- stage D: decision and output register ----------------
    logic dist_cull, plane_cull;
    logic [OUT_INDEX_BITS-1:0] vis_idx_reg, vis_idx_next;
    logic                      vis_reg, vis_next;

    always_comb
    begin
        dist_cull    = control_reg[CTRL_DIST_EN_BIT]
                     && (CMP_BITS'(sum_c_reg) > CMP_BITS'(lim2_c_reg));
        plane_cull   = control_reg[CTRL_FRUSTUM_EN_BIT] && (|outside);
        vis_next     = !(dist_cull || plane_cull);
        vis_idx_next = OUT_INDEX_BITS'(idx_c_reg);
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        idx_a_reg   <= idx_a_next;
        cx_a_reg    <= cx_a_next;
        cy_a_reg    <= cy_a_next;
        cz_a_reg    <= cz_a_next;
        r_a_reg     <= r_a_next;
        d_a_reg     <= d_a_next;
        sq_b_reg    <= sq_b_next;
        lim_b_reg   <= lim_b_next;
        idx_b_reg   <= idx_b_next;
        sum_c_reg   <= sum_c_next;
        lim2_c_reg  <= lim2_c_next;
        idx_c_reg   <= idx_c_next;
        vis_idx_reg <= vis_idx_next;
        vis_reg     <= vis_next;
    end

    assign done          = done_reg;
    assign visible_index = vis_idx_reg;
    assign is_visible    = vis_reg;

    // ---------------- checks ----------------
    logic culls_off;

    assign culls_off = !control_reg[CTRL_DIST_EN_BIT] && !control_reg[CTRL_FRUSTUM_EN_BIT];

    `SFDC_ASSERT_IMPL(a_latency, accept, ##4 done)
    `SFDC_ASSERT_IMPL(a_no_stray_done, done, $past(accept, 4))
    `SFDC_ASSERT_NEXT(a_chain, va_reg && vb_reg, vc_reg)
    `SFDC_ASSERT_IMPL(a_culls_off, done && culls_off, is_visible)

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for the sphere distance and frustum cull core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sfdc_pkg::*;

    // Four register stages from accept to done; after draining, the bench
    // settles before touching config or ending the run.
    localparam int PIPE_DEPTH      = 4;
    localparam int SETTLE_CYCLES   = 2 * PIPE_DEPTH;
    localparam int RANDOM_PHASES   = 14;
    localparam int ITEMS_PER_PHASE = 100;
    localparam longint UNIT_NORMAL = longint'(1) << NORMAL_FRAC;   // 1.0 in Q1.14

    // One sphere as it goes into the core; center lanes are x, y, z.
    typedef struct {
        logic [INDEX_BITS-1:0]                index;
        logic [2:0][COORD_BITS-1:0]           center;
        logic [RADIUS_BITS-1:0]               radius;
    } sphere_t;

    // One expected result.
    typedef struct packed {
        logic [OUT_INDEX_BITS-1:0] index;
        logic                      visible;
    } verdict_t;

    // Scoreboard: shadows the config registers, predicts the verdict of each
    // accepted sphere and checks results in order.
    class cull_scoreboard;
        logic [PLANE_BITS-1:0]   plane [NUM_PLANES];
        logic [CAMERA_BITS-1:0]  camera;
        logic [CONTROL_BITS-1:0] control;
        verdict_t                verdict_q [$];
        int                      errors;

        function new();
            foreach (plane[i]) plane[i] = '0;
            camera  = '0;
            control = CONTROL_RESET;
            errors  = 0;
        endfunction

        function void flag(string msg);
            errors++;
            $display("%0t ns: %s", $time, msg);
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            if (idx <= REG_PLANE_FAR) plane[idx] = data[PLANE_BITS-1:0];
            else if (idx == REG_CAMERA) camera = data[CAMERA_BITS-1:0];
            else if (idx == REG_CONTROL) control = data[CONTROL_BITS-1:0];
        endfunction

        // signed 16-bit lane k of a packed register
        function longint lane(logic [PLANE_BITS-1:0] r, int k);
            return longint'($signed(r[k*LANE_BITS +: LANE_BITS]));
        endfunction

        function bit predict_visible(sphere_t s);
            longint c [3];
            longint rad, d, dist_sq, reach, plane_dist;
            bit     vis;
            vis = 1'b1;
            rad = longint'(s.radius);
            for (int a = 0; a < 3; a++) c[a] = longint'($signed(s.center[a]));
            // squared distance vs squared (draw distance + radius), both integer (Q.0)
            if (control[CTRL_DIST_EN_BIT]) begin
                dist_sq = 0;
                for (int a = 0; a < 3; a++) begin
                    d = c[a] - lane(camera, a);
                    dist_sq += d * d;
                end
                reach = longint'(control[DRAW_BITS-1:0]) + rad;
                if (dist_sq > reach * reach) vis = 1'b0;
            end
            // planes as loaded, no normalization; Q.14 compare
            if (vis && control[CTRL_FRUSTUM_EN_BIT]) begin
                for (int p = 0; p < NUM_PLANES; p++) begin
                    plane_dist = lane(plane[p], 0) * c[0] + lane(plane[p], 1) * c[1]
                               + lane(plane[p], 2) * c[2] + lane(plane[p], 3) * UNIT_NORMAL;
                    if (plane_dist < -(rad * UNIT_NORMAL)) vis = 1'b0;
                end
            end
            return vis;
        endfunction

        function void note_item(sphere_t s);
            verdict_t v;
            v.index   = s.index;
            v.visible = predict_visible(s);
            verdict_q = {verdict_q, v};
        endfunction

        function void check_result(logic [OUT_INDEX_BITS-1:0] idx, logic vis);
            verdict_t v;
            if (verdict_q.size() == 0) begin
                flag($sformatf("stray result: expected none, actual index %h visible %b",
                               idx, vis));
                return;
            end
            v = verdict_q.pop_front();
            if (idx !== v.index)
                flag($sformatf("visible_index: expected %h actual %h", v.index, idx));
            if (vis !== v.visible)
                flag($sformatf("is_visible for index %h: expected %b actual %b",
                               v.index, v.visible, vis));
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    // DUT-facing signals; every input known from time zero
    logic                          clk           = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          start         = 1'b0;
    logic                          busy;
    logic [INDEX_BITS-1:0]         object_index  = '0;
    logic signed [COORD_BITS-1:0]  center_x      = '0;
    logic signed [COORD_BITS-1:0]  center_y      = '0;
    logic signed [COORD_BITS-1:0]  center_z      = '0;
    logic [RADIUS_BITS-1:0]        sphere_radius = '0;
    logic                          done;
    logic [OUT_INDEX_BITS-1:0]     visible_index;
    logic                          is_visible;
    logic                          cfg_write     = 1'b0;
    logic [CFG_IDX_BITS-1:0]       cfg_index     = '0;
    logic [CFG_DATA_BITS-1:0]      cfg_data      = '0;

    cull_scoreboard sb = new();

    // Scene of the current phase: box center, half extent, draw distance.
    int ctr [3];
    int half_ext;
    int draw_dist;
    bit no_idle;

    sphere_frustum_distance_cull_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .object_index  (object_index),
        .center_x      (center_x),
        .center_y      (center_y),
        .center_z      (center_z),
        .sphere_radius (sphere_radius),
        .done          (done),
        .visible_index (visible_index),
        .is_visible    (is_visible),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Everything is sampled at the rising edge; inputs only move on the
    // falling edge, so no ordering within a step matters.
    always @(posedge clk)
    begin : observe
        sphere_t seen;
        if (rst_n)
        begin
            if (done) sb.check_result(visible_index, is_visible);
            if (start && !busy)
            begin
                seen.index     = object_index;
                seen.center[0] = center_x;
                seen.center[1] = center_y;
                seen.center[2] = center_z;
                seen.radius    = sphere_radius;
                sb.note_item(seen);
            end
            if (cfg_write) sb.write_reg(cfg_index, cfg_data);
        end
    end

    function automatic logic [COORD_BITS-1:0] clamp_coord(longint v);
        if (v > 32767) return 16'h7FFF;
        if (v < -32768) return 16'h8000;
        return COORD_BITS'(v);
    endfunction

    function automatic sphere_t mk(logic [INDEX_BITS-1:0] idx, logic [COORD_BITS-1:0] x,
                                   logic [COORD_BITS-1:0] y, logic [COORD_BITS-1:0] z,
                                   logic [RADIUS_BITS-1:0] r);
        sphere_t s;
        s.index  = idx;
        s.center = {z, y, x};
        s.radius = r;
        return s;
    endfunction

    // Normal n on one axis, offset w in lane 3.
    function automatic logic [PLANE_BITS-1:0] axis_plane(int axis, longint n, longint w);
        logic [PLANE_BITS-1:0] p;
        p = '0;
        p[axis*LANE_BITS +: LANE_BITS] = LANE_BITS'(n);
        p[3*LANE_BITS +: LANE_BITS]    = LANE_BITS'(w);
        return p;
    endfunction

    function automatic logic [LANE_BITS-1:0] extreme_lane();
        case ($urandom_range(0, 3))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    // Random sphere shaped by the current scene: some fully random, the largest
    // share around the box, some hugging a box face or the draw-distance shell.
    function automatic sphere_t make_sphere();
        sphere_t s;
        int kind, axis, off, dl, r;
        s.index  = INDEX_BITS'($urandom);
        r        = $urandom_range(0, half_ext / 2);
        s.radius = RADIUS_BITS'(r);
        kind     = $urandom_range(0, 9);
        axis     = $urandom_range(0, 2);
        dl       = int'($urandom_range(0, 4)) - 2;
        for (int a = 0; a < 3; a++)
        begin
            off = $urandom_range(0, 4 * half_ext);
            s.center[a] = clamp_coord(ctr[a] - 2 * half_ext + off);
        end
        case (kind)
            0, 1:
            begin
                s.center = {16'($urandom), 16'($urandom), 16'($urandom)};
                s.radius = RADIUS_BITS'($urandom);
            end
            6, 7:
            begin
                // inside the box except one axis, which sits a hair off a face
                for (int a = 0; a < 3; a++)
                begin
                    off = $urandom_range(0, 2 * half_ext);
                    s.center[a] = clamp_coord(ctr[a] - half_ext + off);
                end
                if ($urandom_range(0, 1))
                    s.center[axis] = clamp_coord(ctr[axis] - half_ext - r + dl);
                else
                    s.center[axis] = clamp_coord(ctr[axis] + half_ext + r + dl);
            end
            8, 9:
            begin
                // right at draw distance + radius from the box center
                for (int a = 0; a < 3; a++) s.center[a] = clamp_coord(ctr[a]);
                off = draw_dist + r + dl;
                s.center[axis] = clamp_coord($urandom_range(0, 1) ? ctr[axis] + off
                                                                  : ctr[axis] - off);
            end
            default: ;
        endcase
        return s;
    endfunction

    // Sender side: optional gap, then hold start until the item is taken.
    task automatic send_item(sphere_t s);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start         <= 1'b1;
        object_index  <= s.index;
        center_x      <= s.center[0];
        center_y      <= s.center[1];
        center_z      <= s.center[2];
        sphere_radius <= s.radius;
        @(posedge clk);
        while (busy !== 1'b0) @(posedge clk);
        @(negedge clk);
    endtask

    // Stop sending and let every expected result come back.
    task automatic drain_pipe();
        start <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic load_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // Upper data bits carry junk; the core must mask them.
    task automatic load_camera(logic [CAMERA_BITS-1:0] cam);
        logic [CFG_DATA_BITS-1:0] data;
        data = {$urandom, $urandom};
        data[CAMERA_BITS-1:0] = cam;
        load_reg(REG_CAMERA, data);
    endtask

    task automatic load_control(bit dist_on, bit frustum_on, logic [DRAW_BITS-1:0] reach);
        logic [CFG_DATA_BITS-1:0] data;
        data = {$urandom, $urandom};
        data[DRAW_BITS-1:0]         = reach;
        data[CTRL_DIST_EN_BIT]      = dist_on;
        data[CTRL_FRUSTUM_EN_BIT]   = frustum_on;
        load_reg(REG_CONTROL, data);
    endtask

    // Axis-aligned box around ctr; skewed gives unnormalized normals and
    // knocks one plane out to all zero.
    task automatic load_box(bit skewed);
        longint lo, hi, pos_n, neg_n;
        for (int a = 0; a < 3; a++)
        begin
            lo    = ctr[a] - half_ext;
            hi    = ctr[a] + half_ext;
            pos_n = skewed ? longint'($urandom_range(1, 32767)) : UNIT_NORMAL;
            neg_n = skewed ? -longint'($urandom_range(1, 32768)) : -UNIT_NORMAL;
            load_reg(CFG_IDX_BITS'(REG_PLANE_LEFT + 2 * a), axis_plane(a, pos_n, -lo));
            load_reg(CFG_IDX_BITS'(REG_PLANE_RIGHT + 2 * a), axis_plane(a, neg_n, hi));
        end
        if (skewed) load_reg(CFG_IDX_BITS'($urandom_range(REG_PLANE_LEFT, REG_PLANE_FAR)), '0);
    endtask

    // Raw random planes; sparse leaves about half of them zero.
    task automatic load_random_planes(bit sparse);
        logic [PLANE_BITS-1:0] word;
        for (int p = REG_PLANE_LEFT; p <= REG_PLANE_FAR; p++)
        begin
            word = {$urandom, $urandom};
            if (sparse && $urandom_range(0, 1)) word = '0;
            load_reg(CFG_IDX_BITS'(p), word);
        end
    endtask

    // New scene and register setting; the pipe is empty when this runs.
    task automatic setup_phase(int kind);
        logic [CAMERA_BITS-1:0] cam_at_ctr;
        for (int a = 0; a < 3; a++) ctr[a] = int'($urandom_range(0, 16000)) - 8000;
        half_ext   = $urandom_range(64, 6000);
        draw_dist  = $urandom_range(0, 3 * half_ext);
        no_idle    = ($urandom_range(0, 3) == 0);
        cam_at_ctr = {16'(ctr[2]), 16'(ctr[1]), 16'(ctr[0])};
        case (kind)
            0:
            begin
                load_box(1'b0);
                load_camera({$urandom, 16'($urandom)});
                load_control(1'b0, 1'b1, DRAW_BITS'(draw_dist));
            end
            1:
            begin
                load_random_planes(1'b0);
                load_camera(cam_at_ctr);
                load_control(1'b1, 1'b0, DRAW_BITS'(draw_dist));
            end
            2:
            begin
                load_box(1'b0);
                load_camera(cam_at_ctr);
                load_control(1'b1, 1'b1, DRAW_BITS'(draw_dist));
            end
            3:
            begin
                // both culls off: everything visible whatever the planes say
                load_random_planes(1'b0);
                load_camera({$urandom, 16'($urandom)});
                load_control(1'b0, 1'b0, DRAW_BITS'($urandom));
            end
            4:
            begin
                load_random_planes(1'b1);
                load_camera(cam_at_ctr);
                load_control(1'($urandom_range(0, 1)), 1'b1, DRAW_BITS'(draw_dist));
            end
            5:
            begin
                // register extremes, both culls on
                for (int p = REG_PLANE_LEFT; p <= REG_PLANE_FAR; p++)
                    load_reg(CFG_IDX_BITS'(p),
                             {extreme_lane(), extreme_lane(), extreme_lane(), extreme_lane()});
                load_camera({extreme_lane(), extreme_lane(), extreme_lane()});
                load_control(1'b1, 1'b1, $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
            end
            default:
            begin
                load_box(1'b1);
                load_camera(cam_at_ctr);
                load_control(1'b1, 1'b1, DRAW_BITS'(draw_dist));
            end
        endcase
    endtask

    initial
    begin : stimulus
        sphere_t corner [8];
        corner[0] = mk(16'h0000, 16'h0000, 16'h0000, 16'h0000, 15'h0000);
        corner[1] = mk(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 15'h7FFF);
        corner[2] = mk(16'h5555, 16'h8000, 16'h8000, 16'h8000, 15'h0000);
        corner[3] = mk(16'hAAAA, 16'h8000, 16'h7FFF, 16'h8000, 15'h7FFF);
        corner[4] = mk(16'h0001, 16'h7FFF, 16'h8000, 16'h7FFF, 15'h0001);
        corner[5] = mk(16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h5555);
        corner[6] = mk(16'h7FFF, 16'h0001, 16'h0001, 16'h0001, 15'h2AAA);
        corner[7] = mk(16'h00FF, 16'h8000, 16'h0000, 16'h7FFF, 15'h7FFE);
        ctr       = '{0, 0, 0};
        half_ext  = 256;
        draw_dist = 0;
        no_idle   = 1'b0;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset setting: frustum on with all-zero planes, so nothing culls.
        foreach (corner[i]) send_item(corner[i]);
        drain_pipe();

        // Extreme register contents with both culls on, same corner spheres.
        load_reg(REG_PLANE_LEFT,   64'h8000_8000_8000_8000);
        load_reg(REG_PLANE_RIGHT,  64'h7FFF_7FFF_7FFF_7FFF);
        load_reg(REG_PLANE_BOTTOM, 64'h8000_7FFF_8000_7FFF);
        load_reg(REG_PLANE_TOP,    64'h7FFF_8000_7FFF_8000);
        load_reg(REG_PLANE_NEAR,   64'h0000_0000_0000_0000);
        load_reg(REG_PLANE_FAR,    64'hFFFF_FFFF_FFFF_FFFF);
        load_camera(48'h8000_8000_8000);
        load_control(1'b1, 1'b1, 16'hFFFF);
        foreach (corner[i]) send_item(corner[i]);
        drain_pipe();

        // Distance boundary: camera at origin, reach 3 + 2 = 5, so 25 passes.
        load_camera('0);
        load_control(1'b1, 1'b0, 16'd3);
        send_item(mk(16'h0100, 16'd3, 16'd4, 16'd0, 15'd2));
        send_item(mk(16'h0101, 16'd3, 16'd4, 16'd1, 15'd2));
        send_item(mk(16'h0102, -16'sd4, 16'd0, -16'sd3, 15'd2));
        send_item(mk(16'h0103, 16'd0, 16'd0, -16'sd6, 15'd2));
        drain_pipe();

        // Frustum boundary: only x >= 0 plane; touching at -radius stays visible.
        load_reg(REG_PLANE_LEFT, axis_plane(0, UNIT_NORMAL, 0));
        for (int p = REG_PLANE_RIGHT; p <= REG_PLANE_FAR; p++) load_reg(CFG_IDX_BITS'(p), '0);
        load_control(1'b0, 1'b1, 16'd0);
        send_item(mk(16'h0200, -16'sd2, 16'd0, 16'd0, 15'd2));
        send_item(mk(16'h0201, -16'sd3, 16'd0, 16'd0, 15'd2));
        drain_pipe();

        // Random phases cycle through every scene kind twice; each one starts
        // from an empty pipe, which is also the sender's full pause.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            setup_phase(ph % 7);
            repeat (ITEMS_PER_PHASE) send_item(make_sphere());
            drain_pipe();
        end

        if (sb.errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Correct runs finish in well under a tenth of this.
    initial
    begin : watchdog
        #1_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
